FILE: rtl/cdq_pkg.sv
// Package: shared types and constants of the subchannel Q generator.
package cdq_pkg;
   localparam int SectorWidth = 19;
   localparam int TrackWidth  = 7;
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;
   localparam logic [7:0] POINT_A0 = 8'hA0;
   localparam logic [7:0] POINT_A1 = 8'hA1;
   localparam logic [7:0] POINT_A2 = 8'hA2;
   localparam logic [7:0] TRACK_LEAD_OUT = 8'hAA;
   localparam logic [7:0] ODD_MARK = 8'h80;
   localparam logic [7:0] PREGAP_SECTORS = 8'd150;

   typedef struct packed {
      logic [TrackWidth-1:0]  idx;
      logic                   we;
      logic [SectorWidth-1:0] wdata;
      logic                   re;
   } tab_cmd_type;

   // clamp to 99 and convert to packed BCD
   function automatic logic [7:0] bcd(input logic [SectorWidth-1:0] v);
      logic [6:0] c;
      logic [3:0] t;
      logic [6:0] r;
      c = (v > SectorWidth'(99)) ? 7'd99 : v[6:0];
      t = 4'((14'(c) * 14'd103) >> 10);
      r = c - 7'(t * 4'd10);
      if (r >= 7'd10) begin
         t = t + 4'd1;
         r = r - 7'd10;
      end
      return {t, r[3:0]};
   endfunction
endpackage

FILE: rtl/cdq_if.sv
// Interfaces: valid/ready channels for query requests and frame responses.
interface cdq_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [6:0]  table_index;
   logic [18:0] table_sector;
   logic [18:0] sector;
   modport source (output valid, kind, table_index, table_sector, sector, input ready);
   modport sink   (input valid, kind, table_index, table_sector, sector, output ready);
endinterface

interface cdq_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] q_bytes_0_to_7;
   logic [31:0] q_bytes_8_to_11;
   modport source (output valid, q_bytes_0_to_7, q_bytes_8_to_11, input ready);
   modport sink   (input valid, q_bytes_0_to_7, q_bytes_8_to_11, output ready);
endinterface

FILE: rtl/cd_subchannel_q_generator.sv
// Top level: subchannel Q frame sequencer around the track start table.
// Usage
//   req channel: kind 0 loads table_sector into entry table_index (no
//   response); kind 1 asks for the Q frame of absolute sector `sector`.
//   rsp channel: one 96-bit frame per query, byte 0 in the top bits.
//   csr_we/csr_wdata write track_count; write only while idle.
// Timing
//   A load is written at its accepting edge and ready stays high, so loads
//   may follow back to back. A query walks the table with a read state and
//   a compare state per entry, over up to track_count+2 entries, then runs
//   two MSF conversions. A lead-in query instead reduces the sector modulo
//   track_count+3. One item is worked on at a time. The frame sits in an
//   output register; the next request is taken while it waits, and the
//   sequencer holds the new frame until the register is free, so a stalled
//   receiver stalls it.
// Reset
//   Synchronous, active high: control clears, track_count returns to 1.
//   Table contents are undefined until loaded.
module cd_subchannel_q_generator #(
   parameter int TABLE_DEPTH     = 128,
   parameter int LEAD_IN_SECTORS = 4500
) (
   input  logic        clock,
   input  logic        reset,
   cdq_req_if.sink     req,
   cdq_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import cdq_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_LMOD = 4'd1, S_LRD = 4'd2, S_LWT = 4'd3,
      S_SRCH = 4'd4, S_SWT = 4'd5, S_RELRD = 4'd6, S_RELWT = 4'd7, S_M1 = 4'd8,
      S_M2 = 4'd9, S_OUT = 4'd10;
   localparam logic [SectorWidth-1:0] LeadIn = SectorWidth'(LEAD_IN_SECTORS);

   logic [3:0]             st_ff, st_in;
   logic [6:0]             tc_ff;
   logic [SectorWidth-1:0] sec_ff, sec_in;
   logic [7:0]             ent_ff, ent_in;   // lead-in entry or search index
   logic [7:0]             trk_ff, trk_in;
   logic [SectorWidth-1:0] val_ff, val_in;   // lead-in sector copy or track start sector
   logic [23:0]            m1_ff, m1_in;
   logic [23:0]            m2_ff, m2_in;
   logic [7:0]             pt_ff, pt_in;
   logic                   rv_ff, rv_in;
   logic [63:0]            hi_ff, hi_in;
   logic [31:0]            lo_ff, lo_in;
   tab_cmd_type            cmd;
   logic [SectorWidth-1:0] rdata;
   logic                   mstart, mdone;
   logic [SectorWidth-1:0] mval;
   logic [23:0]            msf;
   logic [7:0]             mod;
   logic [SectorWidth-1:0] rel;
   logic [7:0]             b1, b2;
   logic [23:0]            relmsf;
   logic                   pregap;

   cdq_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_tab (.clock, .cmd, .rdata);
   cdq_msf u_msf (.clock, .reset, .start(mstart), .value(mval), .done(mdone), .msf);

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.q_bytes_0_to_7 = hi_ff;
   assign rsp.q_bytes_8_to_11 = lo_ff;

   assign rel    = (sec_ff > val_ff) ? sec_ff - val_ff : '0;
   assign pregap = (trk_ff == 8'd1) && (rel < SectorWidth'(PREGAP_SECTORS));

   always_comb begin
      st_in = st_ff; sec_in = sec_ff; ent_in = ent_ff; trk_in = trk_ff;
      val_in = val_ff; m1_in = m1_ff; m2_in = m2_ff; pt_in = pt_ff; rv_in = rv_ff;
      hi_in = hi_ff; lo_in = lo_ff;
      cmd = '{idx: '0, we: 1'b0, wdata: req.table_sector, re: 1'b0};
      mstart = 1'b0; mval = val_ff;
      mod = ent_ff; b1 = 8'h00; b2 = 8'h00; relmsf = 24'h0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (st_ff)
         S_IDLE: if (req.valid) begin
            sec_in = req.sector;
            if (req.kind == KIND_LOAD) begin
               cmd.idx = req.table_index;
               cmd.we  = 1'b1;
            end else if (req.sector < LeadIn) begin
               // keep the sector aside, the modulo loop consumes sec_ff
               val_in = req.sector;
               ent_in = '0;
               st_in  = S_LMOD;
            end else begin
               ent_in = '0;
               trk_in = 8'(tc_ff) + 8'd1;
               cmd.idx = 7'd1; cmd.re = 1'b1;
               st_in  = S_SRCH;
            end
         end
         // sector mod (3+track_count), one subtraction per cycle, of 16*mod when it fits, else of mod
         S_LMOD: begin
            mod = 8'(tc_ff) + 8'd3;
            if (sec_ff >= SectorWidth'(mod)) begin
               sec_in = sec_ff - SectorWidth'(mod);
               if (sec_ff >= SectorWidth'({mod, 4'b0})) sec_in = sec_ff - SectorWidth'({mod, 4'b0});
            end else begin
               ent_in = 8'(sec_ff);
               sec_in = val_ff;
               st_in  = S_LRD;
            end
         end
         S_LRD: begin
            if (ent_ff == 8'd2) begin
               pt_in = POINT_A2; cmd.idx = tc_ff + 7'd1; cmd.re = (tc_ff != 7'd127);
            end else begin
               pt_in = bcd(SectorWidth'(ent_ff - 8'd2));
               cmd.idx = 7'(ent_ff - 8'd2); cmd.re = 1'b1;
            end
            st_in = S_LWT;
         end
         S_LWT: begin
            if (ent_ff == 8'd0) begin
               pt_in = POINT_A0; m1_in = 24'h010000;
            end else if (ent_ff == 8'd1) begin
               pt_in = POINT_A1; m1_in = {bcd(SectorWidth'(tc_ff)), 16'h0};
            end
            if (ent_ff >= 8'd2) begin
               if (ent_ff == 8'd3) mval = SectorWidth'(PREGAP_SECTORS);
               else if (ent_ff == 8'd2 && tc_ff == 7'd127) mval = '0;
               else mval = (rdata > LeadIn) ? rdata - LeadIn : '0;
               mstart = 1'b1;
               st_in = S_M1;
            end else begin
               mval = sec_ff; mstart = 1'b1; st_in = S_M2;
            end
         end
         S_SRCH: st_in = S_SWT;
         S_SWT: begin
            if (rdata > sec_ff || (ent_ff + 8'd1 >= 8'(tc_ff) + 8'd2)) begin
               if (rdata > sec_ff) trk_in = ent_ff;
               st_in = S_RELRD;
            end else begin
               ent_in = ent_ff + 8'd1;
               cmd.idx = 7'(ent_ff + 8'd2);
               cmd.re = (ent_ff != 8'd126);
               st_in = S_SRCH;
            end
         end
         S_RELRD: begin
            cmd.idx = trk_ff[6:0]; cmd.re = (trk_ff < 8'd128);
            st_in = S_RELWT;
         end
         S_RELWT: begin
            val_in = (trk_ff >= 8'd128) ? '0 : rdata;
            st_in = S_M1;
            mstart = 1'b1;
            mval = ((trk_ff >= 8'd128) ? '0 : rdata);
            mval = (sec_ff > mval) ? sec_ff - mval : '0;
            if (trk_ff == 8'd1) mval = (mval >= SectorWidth'(PREGAP_SECTORS))
                                    ? mval - SectorWidth'(PREGAP_SECTORS) : mval;
            pt_in = 8'hFF; // marks program area
         end
         S_M1: if (mdone) begin
            m1_in = msf;
            mstart = 1'b1;
            if (pt_ff == 8'hFF && trk_ff != 8'hFF)
               mval = (sec_ff > LeadIn) ? sec_ff - LeadIn : '0;
            else
               mval = sec_ff;
            st_in = S_M2;
         end
         S_M2: if (mdone) begin
            st_in = S_OUT;
            m1_in = m1_ff;
            m2_in = msf;
         end
         S_OUT: if (!rv_ff || rsp.ready) begin
            rv_in = 1'b1;
            st_in = S_IDLE;
            if (pt_ff == 8'hFF) begin
               relmsf = m1_ff;
               b1 = (trk_ff == 8'(tc_ff) + 8'd1) ? TRACK_LEAD_OUT : bcd(SectorWidth'(trk_ff));
               if (pregap) begin
                  b2 = 8'h00;
                  relmsf = {8'h00, bcd(SectorWidth'(1) - SectorWidth'(rel >= 75)),
                            bcd(SectorWidth'(74) - ((rel >= 75) ? rel - 75 : rel))};
               end else b2 = 8'h01;
               hi_in = {8'h01, b1, b2, relmsf, 8'h00, m2_ff[23:16]};
               lo_in = {m2_ff[15:0], 8'h00, sec_ff[0] ? ODD_MARK : 8'h00};
            end else begin
               hi_in = {8'h01, 8'h00, pt_ff, m2_ff, 8'h00, m1_ff[23:16]};
               lo_in = {m1_ff[15:0], 16'h0};
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0; tc_ff <= 7'd1;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in;
         if (csr_we) tc_ff <= csr_wdata;
      end
      sec_ff <= sec_in; ent_ff <= ent_in; trk_ff <= trk_in; val_ff <= val_in;
      m1_ff <= m1_in; m2_ff <= m2_in; pt_ff <= pt_in; hi_ff <= hi_in; lo_ff <= lo_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (st_ff == S_IDLE)) else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp.ready) |=> rv_ff && $stable(hi_ff)) else $error("frame dropped");
   a_out_one: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_OUT && st_in == S_IDLE) |=> rv_ff) else $error("frame not shown");
endmodule

FILE: rtl/cdq_table.sv
// Track start table: single-port synchronous memory with a registered read port.
module cdq_table #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                       clock,
   input  cdq_pkg::tab_cmd_type       cmd,
   output logic [cdq_pkg::SectorWidth-1:0] rdata
);
   import cdq_pkg::*;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   logic [SectorWidth-1:0] mem [TABLE_DEPTH];
   logic [SectorWidth-1:0] rdata_ff;
   logic                   oor;

   assign oor = 32'(cmd.idx) >= TABLE_DEPTH;

   always_ff @(posedge clock) begin
      if (cmd.we && !oor) mem[cmd.idx[AW-1:0]] <= cmd.wdata;
      if (cmd.re) rdata_ff <= oor ? '0 : mem[cmd.idx[AW-1:0]];
   end
   assign rdata = rdata_ff;
endmodule

FILE: rtl/cdq_msf.sv
// Sector to BCD minutes/seconds/frames by reciprocal multiplication.
module cdq_msf (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [cdq_pkg::SectorWidth-1:0] value,
   output logic                            done,
   output logic [23:0]                     msf
);
   import cdq_pkg::*;
   // x/75 = (x * 447393) >> 25 and q/60 = (q * 8739) >> 19, exact over the ranges here
   localparam logic [18:0] Recip75 = 19'd447393;
   localparam logic [13:0] Recip60 = 14'd8739;

   logic [3:0]             phase_ff, phase_in;
   logic [SectorWidth-1:0] val_ff, val_in;
   logic [12:0]            quo_ff, quo_in;   // whole seconds
   logic [6:0]             min_ff, min_in;
   logic [5:0]             sec_ff, sec_in;
   logic [6:0]             frm_ff, frm_in;
   logic [37:0]            prod75;
   logic [26:0]            prod60;
   logic [SectorWidth-1:0] frm_wide;
   logic [12:0]            sec_wide;

   assign prod75   = 38'(val_ff) * 38'(Recip75);
   assign prod60   = 27'(quo_ff) * 27'(Recip60);
   assign frm_wide = val_ff - SectorWidth'(quo_ff) * SectorWidth'(75);
   assign sec_wide = quo_ff - 13'(min_ff) * 13'd60;

   // seconds, then minutes and frames, then seconds within the minute
   always_comb begin
      phase_in = {phase_ff[2:0], start};
      val_in   = start ? value : val_ff;
      quo_in   = phase_ff[0] ? 13'(prod75 >> 25) : quo_ff;
      min_in   = phase_ff[1] ? 7'(prod60 >> 19) : min_ff;
      frm_in   = phase_ff[1] ? 7'(frm_wide) : frm_ff;
      sec_in   = phase_ff[2] ? 6'(sec_wide) : sec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= '0;
      else phase_ff <= phase_in;
      val_ff <= val_in;
      quo_ff <= quo_in;
      min_ff <= min_in;
      sec_ff <= sec_in;
      frm_ff <= frm_in;
   end

   assign done = phase_ff[3];
   assign msf  = {bcd(SectorWidth'(min_ff)), bcd(SectorWidth'(sec_ff)),
                  bcd(SectorWidth'(frm_ff))};
endmodule

FILE: tb/cdq_frame_checker.sv
// Checker: mirrors the track table, predicts each Q frame and compares responses.
module cdq_frame_checker #(
   parameter int TABLE_DEPTH     = 128,
   parameter int LEAD_IN_SECTORS = 4500
) (
   input  logic  clock,
   input  logic  reset,
   cdq_req_if    req,
   cdq_rsp_if    rsp,
   input  logic  csr_we,
   input  logic [6:0] csr_wdata,
   output int    fail_count,
   output int    frames_owed,
   output int    frames_checked,
   output logic  handshake_seen
);
   import cdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [SectorWidth-1:0] start_sector [TABLE_DEPTH];
   int unsigned            tracks;
   logic [95:0]            owed_frames [$];

   function automatic int unsigned start_of(input int unsigned i);
      if (i >= TABLE_DEPTH) return 0;
      return start_sector[i];
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      if (v > 99) v = 99;
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic logic [23:0] to_msf(input int unsigned s);
      return {to_bcd(s / 75 / 60), to_bcd((s / 75) % 60), to_bcd(s % 75)};
   endfunction

   function automatic int unsigned clip_sub(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic logic [95:0] predict_frame(input int unsigned sec);
      logic [7:0]  b [12];
      logic [95:0] f;
      int unsigned entry, trk, rel;
      for (int k = 0; k < 12; k++) b[k] = 8'h00;
      b[0] = 8'h01;
      if (sec < LEAD_IN_SECTORS) begin
         entry = sec % (3 + tracks);
         if (entry == 0) begin
            b[2] = POINT_A0;
            b[7] = 8'h01;
         end else if (entry == 1) begin
            b[2] = POINT_A1;
            b[7] = to_bcd(tracks);
         end else if (entry == 2) begin
            b[2] = POINT_A2;
            {b[7], b[8], b[9]} = to_msf(clip_sub(start_of(tracks + 1), LEAD_IN_SECTORS));
         end else begin
            trk  = entry - 2;
            b[2] = to_bcd(trk);
            {b[7], b[8], b[9]} = to_msf((trk == 1) ? 150 :
                                        clip_sub(start_of(trk), LEAD_IN_SECTORS));
         end
         {b[3], b[4], b[5]} = to_msf(sec);
      end else begin
         trk = tracks + 1;
         for (int unsigned i = 0; i < tracks + 2; i++) begin
            if (start_of(i + 1) > sec) begin
               trk = i;
               break;
            end
         end
         rel  = clip_sub(sec, start_of(trk));
         b[1] = (trk == tracks + 1) ? TRACK_LEAD_OUT : to_bcd(trk);
         // track 1 pregap: index 0, time counts down to zero
         if (trk == 1 && rel < 150) begin
            b[4] = to_bcd(1 - rel / 75);
            b[5] = to_bcd(74 - rel % 75);
         end else begin
            b[2] = 8'h01;
            {b[3], b[4], b[5]} = to_msf((trk == 1) ? rel - 150 : rel);
         end
         {b[7], b[8], b[9]} = to_msf(clip_sub(sec, LEAD_IN_SECTORS));
         b[11] = sec[0] ? ODD_MARK : 8'h00;
      end
      for (int k = 0; k < 12; k++) f[95 - 8*k -: 8] = b[k];
      return f;
   endfunction

   always @(posedge clock) begin
      logic [95:0] want;
      if (reset) begin
         tracks = 1;
         owed_frames.delete();
         fail_count = 0;
         frames_checked = 0;
      end else begin
         if (csr_we) tracks = csr_wdata;
         // retire the oldest frame before queueing a new one
         if (rsp.valid && rsp.ready) begin
            if (owed_frames.size() == 0) begin
               $error("unexpected frame %h %h", rsp.q_bytes_0_to_7, rsp.q_bytes_8_to_11);
               fail_count++;
            end else begin
               want = owed_frames.pop_front();
               frames_checked++;
               if (rsp.q_bytes_0_to_7 !== want[95:32]) begin
                  $error("q_bytes_0_to_7: expected %h, got %h", want[95:32],
                         rsp.q_bytes_0_to_7);
                  fail_count++;
               end
               if (rsp.q_bytes_8_to_11 !== want[31:0]) begin
                  $error("q_bytes_8_to_11: expected %h, got %h", want[31:0],
                         rsp.q_bytes_8_to_11);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.kind == KIND_LOAD) begin
               if (req.table_index < TABLE_DEPTH)
                  start_sector[req.table_index] = req.table_sector;
            end else begin
               owed_frames.push_back(predict_frame(req.sector));
            end
         end
      end
      frames_owed    = owed_frames.size();
      handshake_seen = (req.valid && req.ready) || (rsp.valid && rsp.ready);
   end
endmodule

FILE: tb/cd_subchannel_q_generator_tb.sv
// Testbench top: clock, reset, stimulus, response stalls, watchdog and verdict.
module cd_subchannel_q_generator_tb;
   import cdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 60000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [6:0] csr_wdata = 7'd0;

   cdq_req_if req ();
   cdq_rsp_if rsp ();

   int fail_count, frames_owed, frames_checked;
   logic handshake_seen;
   int item_total = 0;
   int query_total = 0;
   int idle_mode = 0;
   int span_end = 10000;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit long_hold_done = 0;

   cd_subchannel_q_generator u_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   cdq_frame_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .frames_owed(frames_owed), .frames_checked(frames_checked),
      .handshake_seen(handshake_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_LOAD;
      req.table_index = '0;
      req.table_sector = '0;
      req.sector = '0;
      rsp.ready = 1'b0;
   end

   // receiver: random stalls by mode, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (!long_hold_done && item_total >= 300) begin
         long_hold_done = 1;
         hold_left = 2500;
         rsp.ready <= 1'b0;
      end else if (idle_mode == 2) begin
         rsp.ready <= ($urandom_range(99) >= 62);
      end else if (idle_mode == 3) begin
         rsp.ready <= ($urandom_range(99) >= 32);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || handshake_seen) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic kind, input int idx, input int tsec, input int sec);
      int gap_pct;
      idle_mode = (item_total / 40) % 4;
      gap_pct = (idle_mode == 1) ? 62 : (idle_mode == 3) ? 32 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req.valid <= 1'b1;
      req.kind <= kind;
      req.table_index <= idx[6:0];
      req.table_sector <= tsec[18:0];
      req.sector <= sec[18:0];
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      item_total++;
      if (kind == KIND_QUERY) query_total++;
   endtask

   // hold until every frame is back, then let a trailing load settle
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (frames_owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_tracks(input int tc);
      csr_we <= 1'b1;
      csr_wdata <= tc[6:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic fill_track_table(input int tc);
      int s, step;
      step = 20000 / tc + 1;
      send_item(KIND_LOAD, 0, $urandom_range(0, 4500), 0);
      s = 4500 + $urandom_range(0, 300);
      send_item(KIND_LOAD, 1, s, 0);
      for (int i = 2; i <= tc + 2; i++) begin
         s = s + $urandom_range(1, step);
         send_item(KIND_LOAD, i, s, 0);
         if (i == tc + 1) span_end = s;
      end
   endtask

   task automatic random_item(input int tc);
      int r;
      r = $urandom_range(99);
      if (r < 12) begin
         if ($urandom_range(9) < 7)
            send_item(KIND_LOAD, $urandom_range(tc + 3, 127), $urandom_range(0, 524287), 0);
         else
            send_item(KIND_LOAD, $urandom_range(0, 127), $urandom_range(0, 524287), 0);
      end else if (r < 40) begin
         send_item(KIND_QUERY, $urandom_range(0, 127), $urandom_range(0, 524287),
                   $urandom_range(0, 4499));
      end else if (r < 88) begin
         send_item(KIND_QUERY, 0, 0, $urandom_range(4500, span_end + 2000));
      end else if (r < 98) begin
         send_item(KIND_QUERY, 0, 0, $urandom_range(0, 60000));
      end else begin
         send_item(KIND_QUERY, 0, 0, $urandom_range(0, 524287));
      end
   endtask

   initial begin
      static int tc_plan [10] = '{1, 99, 2, 5, 13, 40, 77, 3, 99, 1};
      static int directed [14] = '{0, 1, 2, 3, 4499, 4500, 4574, 4575, 4649, 4650,
                                  5499, 5500, 524286, 524287};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fixed single-track disc, every entry written once
      set_tracks(1);
      for (int i = 0; i < 128; i++)
         send_item(KIND_LOAD, i, (i == 0) ? 0 : (i == 1) ? 4500 : (i == 2) ? 5500 :
                   524287, 0);
      span_end = 5500;
      foreach (directed[i]) send_item(KIND_QUERY, 0, 0, directed[i]);
      // lead-out start inside the lead-in: A2 time saturates to zero
      send_item(KIND_LOAD, 2, 100, 0);
      send_item(KIND_QUERY, 0, 0, 2);
      send_item(KIND_QUERY, 0, 0, 4600);
      send_item(KIND_LOAD, 2, 5500, 0);

      foreach (tc_plan[p]) begin
         drain();
         set_tracks(tc_plan[p]);
         fill_track_table(tc_plan[p]);
         for (int n = 0; n < 33; n++) random_item(tc_plan[p]);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d transactions, %0d frame queries over %0d track counts (1 to 99),",
               item_total, query_total, 10);
      $display("%0d frames checked across lead-in, pregap, program and lead-out sectors.",
               frames_checked);
      if (fail_count == 0 && frames_owed == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
